/* src/tga_rle_pkg.sv */
// ============================================================================
// TGA RLE decoder package
// Shared types and constants of the truecolor TGA stream decoder.
// ============================================================================
`default_nettype none

package tga_rle_pkg;

    localparam int unsigned COORD_BITS_DEFAULT = 16;

    localparam logic [15:0] MAX_WIDTH_RESET  = 16'd4096;
    localparam logic [15:0] MAX_HEIGHT_RESET = 16'd4096;

    // configuration register indexes
    localparam logic CFG_MAX_WIDTH  = 1'b0;
    localparam logic CFG_MAX_HEIGHT = 1'b1;

    // header byte offsets
    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_CMAP      = 5'd1;
    localparam logic [4:0] HDR_KIND      = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_ATTR      = 5'd17;

    localparam logic [7:0] KIND_RAW  = 8'd2;
    localparam logic [7:0] KIND_RLE  = 8'd10;
    localparam logic [7:0] DEPTH_24  = 8'd24;
    localparam logic [7:0] DEPTH_32  = 8'd32;

    localparam logic [7:0] ATTR_TOP_DOWN  = 8'h20;
    localparam logic [7:0] ATTR_RIGHT     = 8'h10;
    localparam logic [7:0] ATTR_ALPHA_MSK = 8'h0F;
    localparam logic [3:0] ALPHA_BITS_8   = 4'd8;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_COLORMAP   = 3'd1,
        ST_TYPE_DEPTH = 3'd2,
        ST_ATTRIB     = 3'd3,
        ST_SIZE       = 3'd4,
        ST_TRUNCATED  = 3'd5,
        ST_OVERFLOW   = 3'd6
    } status_t;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_IDSKIP = 5'b00010,
        PH_PACKET = 5'b00100,
        PH_PIXEL  = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

/* src/tga_rle_in_if.sv */
// ============================================================================
// TGA RLE input channel
// Valid/ready byte channel carrying one file byte and its end mark.
// ============================================================================
`default_nettype none

interface tga_rle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

/* src/tga_rle_out_if.sv */
// ============================================================================
// TGA RLE output channel
// Valid/ready channel carrying one decoded pixel run and its status.
// ============================================================================
`default_nettype none

interface tga_rle_out_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [7:0]           alpha;
    logic [15:0]          column;
    logic [15:0]          row;
    logic [7:0]           run_length;
    logic                 final_res;
    tga_rle_pkg::status_t status;
    logic                 has_alpha;

    modport source (
        output valid, output red, output green, output blue, output alpha,
        output column, output row, output run_length, output final_res,
        output status, output has_alpha, input ready
    );
    modport sink (
        input valid, input red, input green, input blue, input alpha,
        input column, input row, input run_length, input final_res,
        input status, input has_alpha, output ready
    );
endinterface

`default_nettype wire

/* src/tga_rle_stream_decoder.sv */
// ============================================================================
// TGA truecolor stream decoder
// Parses the header, skips the ID field and decodes raw or RLE pixel runs.
// ============================================================================
// The block takes one file byte per beat and can accept a beat in every
// cycle while not stalled: each byte updates the header, packet and pixel
// counters, and a finished run lands in the output register in the cycle
// after its last byte is accepted. Input stalls only while that register
// holds a run that the consumer has not yet taken. Configuration writes to
// max_width and max_height must happen between files.
`default_nettype none

module tga_rle_stream_decoder #(
    parameter int unsigned COORD_BITS = tga_rle_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    tga_rle_in_if.sink       in_ch,
    tga_rle_out_if.source    out_ch
);

    localparam logic [15:0] COORD_MASK = 16'((32'd1 << COORD_BITS) - 32'd1);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic [7:0]           alpha;
        logic [15:0]          column;
        logic [15:0]          row;
        logic [7:0]           run_length;
        logic                 final_res;
        tga_rle_pkg::status_t status;
        logic                 has_alpha;
    } result_t;

    logic [15:0] max_width_reg, max_height_reg;

    tga_rle_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  header_index_reg, header_index_next;
    logic [7:0]  id_skip_left_reg, id_skip_left_next;
    logic        colormap_present_reg, colormap_present_next;
    logic [7:0]  image_kind_reg, image_kind_next;
    logic [7:0]  bits_per_pixel_reg, bits_per_pixel_next;
    logic [7:0]  attribute_bits_reg, attribute_bits_next;
    logic [15:0] image_columns_reg, image_columns_next;
    logic [15:0] image_rows_reg, image_rows_next;
    coord_t      column_count_reg, column_count_next;
    coord_t      row_count_reg, row_count_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic        packet_repeats_reg, packet_repeats_next;
    logic [1:0]  pixel_byte_index_reg, pixel_byte_index_next;
    logic [23:0] pixel_bytes_reg, pixel_bytes_next;

    logic        out_valid_reg, out_valid_next;
    result_t     result_reg, result_next;

    logic        in_fire;
    logic        final_c, emit_c, clear_c, give_c;
    logic        alpha8_c;
    tga_rle_pkg::status_t status_c;
    logic [7:0]  run_c, len_c, abyte_c;
    logic [16:0] packet_end_c, col_sum_c;
    logic [2:0]  byte_inc_c, nbytes_c;
    logic [23:0] pix_c;
    logic [15:0] row_flip_c;
    coord_t      row_c;
    logic [COORD_BITS:0] row_inc_c;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_width_reg  <= tga_rle_pkg::MAX_WIDTH_RESET;
            max_height_reg <= tga_rle_pkg::MAX_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == tga_rle_pkg::CFG_MAX_WIDTH)
                max_width_reg <= cfg_data;
            else
                max_height_reg <= cfg_data;
        end
    end

    always_comb
    begin
        phase_next            = phase_reg;
        header_index_next     = header_index_reg;
        id_skip_left_next     = id_skip_left_reg;
        colormap_present_next = colormap_present_reg;
        image_kind_next       = image_kind_reg;
        bits_per_pixel_next   = bits_per_pixel_reg;
        attribute_bits_next   = attribute_bits_reg;
        image_columns_next    = image_columns_reg;
        image_rows_next       = image_rows_reg;
        column_count_next     = column_count_reg;
        row_count_next        = row_count_reg;
        packet_left_next      = packet_left_reg;
        packet_repeats_next   = packet_repeats_reg;
        pixel_byte_index_next = pixel_byte_index_reg;
        pixel_bytes_next      = pixel_bytes_reg;

        final_c  = 1'b0;
        emit_c   = 1'b0;
        clear_c  = 1'b0;
        give_c   = 1'b0;
        status_c = tga_rle_pkg::ST_OK;
        alpha8_c = (attribute_bits_reg & tga_rle_pkg::ATTR_ALPHA_MSK)
                   == {4'd0, tga_rle_pkg::ALPHA_BITS_8};
        run_c        = {1'b0, in_ch.data_byte[6:0]} + 8'd1;
        packet_end_c = {1'b0, 16'(column_count_reg)} + {9'd0, run_c};
        len_c        = 8'd0;
        abyte_c      = tga_rle_pkg::ALPHA_OPAQUE;
        byte_inc_c   = {1'b0, pixel_byte_index_reg} + 3'd1;
        nbytes_c     = (bits_per_pixel_reg == tga_rle_pkg::DEPTH_32) ? 3'd4 : 3'd3;
        pix_c        = pixel_bytes_reg;
        col_sum_c    = 17'd0;
        row_inc_c    = {1'b0, row_count_reg} + {{COORD_BITS{1'b0}}, 1'b1};
        row_flip_c   = image_rows_reg - 16'd1 - 16'(row_count_reg);
        row_c        = (attribute_bits_reg & tga_rle_pkg::ATTR_TOP_DOWN) != 8'd0
                       ? row_count_reg : row_flip_c[COORD_BITS-1:0];

        result_next = '0;

        if (in_fire)
        begin
            case (phase_reg)
                tga_rle_pkg::PH_HEADER:
                begin
                    case (header_index_reg)
                        tga_rle_pkg::HDR_ID_LEN:    id_skip_left_next = in_ch.data_byte;
                        tga_rle_pkg::HDR_CMAP:
                            colormap_present_next = in_ch.data_byte != 8'd0;
                        tga_rle_pkg::HDR_KIND:      image_kind_next = in_ch.data_byte;
                        tga_rle_pkg::HDR_WIDTH_LO:
                            image_columns_next[7:0] = in_ch.data_byte;
                        tga_rle_pkg::HDR_WIDTH_HI:
                            image_columns_next[15:8] = in_ch.data_byte;
                        tga_rle_pkg::HDR_HEIGHT_LO:
                            image_rows_next[7:0] = in_ch.data_byte;
                        tga_rle_pkg::HDR_HEIGHT_HI:
                            image_rows_next[15:8] = in_ch.data_byte;
                        tga_rle_pkg::HDR_DEPTH:     bits_per_pixel_next = in_ch.data_byte;
                        tga_rle_pkg::HDR_ATTR:      attribute_bits_next = in_ch.data_byte;
                        default: ;
                    endcase
                    if (header_index_reg < tga_rle_pkg::HDR_ATTR)
                    begin
                        header_index_next = header_index_reg + 5'd1;
                    end
                    else
                    begin
                        alpha8_c = (attribute_bits_next & tga_rle_pkg::ATTR_ALPHA_MSK)
                                   == {4'd0, tga_rle_pkg::ALPHA_BITS_8};
                        if (image_columns_next == 16'd0
                            || image_columns_next > max_width_reg
                            || image_columns_next > COORD_MASK
                            || image_rows_next == 16'd0
                            || image_rows_next > max_height_reg
                            || image_rows_next > COORD_MASK)
                            status_c = tga_rle_pkg::ST_SIZE;
                        else if (colormap_present_next)
                            status_c = tga_rle_pkg::ST_COLORMAP;
                        else if ((image_kind_next != tga_rle_pkg::KIND_RAW
                                  && image_kind_next != tga_rle_pkg::KIND_RLE)
                                 || (bits_per_pixel_next != tga_rle_pkg::DEPTH_24
                                     && bits_per_pixel_next != tga_rle_pkg::DEPTH_32))
                            status_c = tga_rle_pkg::ST_TYPE_DEPTH;
                        else if ((attribute_bits_next & tga_rle_pkg::ATTR_RIGHT) != 8'd0
                                 || ((attribute_bits_next & tga_rle_pkg::ATTR_ALPHA_MSK)
                                         != 8'd0
                                     && !alpha8_c))
                            status_c = tga_rle_pkg::ST_ATTRIB;

                        if (status_c != tga_rle_pkg::ST_OK)
                            final_c = 1'b1;
                        else if (id_skip_left_next != 8'd0)
                            phase_next = tga_rle_pkg::PH_IDSKIP;
                        else if (image_kind_next == tga_rle_pkg::KIND_RLE)
                            phase_next = tga_rle_pkg::PH_PACKET;
                        else
                            phase_next = tga_rle_pkg::PH_PIXEL;
                    end
                end

                tga_rle_pkg::PH_IDSKIP:
                begin
                    id_skip_left_next = id_skip_left_reg - 8'd1;
                    if (id_skip_left_next == 8'd0)
                        phase_next = (image_kind_reg == tga_rle_pkg::KIND_RLE)
                                     ? tga_rle_pkg::PH_PACKET : tga_rle_pkg::PH_PIXEL;
                end

                tga_rle_pkg::PH_PACKET:
                begin
                    packet_repeats_next = in_ch.data_byte[7];
                    if (packet_end_c > {1'b0, image_columns_reg})
                    begin
                        status_c = tga_rle_pkg::ST_OVERFLOW;
                        final_c  = 1'b1;
                    end
                    else
                    begin
                        packet_left_next      = run_c;
                        pixel_byte_index_next = 2'd0;
                        phase_next            = tga_rle_pkg::PH_PIXEL;
                    end
                end

                tga_rle_pkg::PH_PIXEL:
                begin
                    case (pixel_byte_index_reg)
                        2'd0: pix_c = {16'd0, in_ch.data_byte};
                        2'd1: pix_c = pixel_bytes_reg | {8'd0, in_ch.data_byte, 8'd0};
                        2'd2: pix_c = pixel_bytes_reg | {in_ch.data_byte, 16'd0};
                        default: abyte_c = in_ch.data_byte;
                    endcase
                    pixel_bytes_next      = pix_c;
                    pixel_byte_index_next = byte_inc_c[1:0];
                    if (byte_inc_c >= nbytes_c)
                    begin
                        pixel_byte_index_next = 2'd0;
                        emit_c = 1'b1;
                        if (image_kind_reg == tga_rle_pkg::KIND_RLE)
                        begin
                            if (packet_repeats_reg)
                            begin
                                len_c            = packet_left_reg;
                                packet_left_next = 8'd0;
                            end
                            else
                            begin
                                len_c            = 8'd1;
                                packet_left_next = packet_left_reg - 8'd1;
                            end
                            if (packet_left_next == 8'd0)
                                phase_next = tga_rle_pkg::PH_PACKET;
                        end
                        else
                        begin
                            len_c = 8'd1;
                        end

                        result_next.blue       = pix_c[7:0];
                        result_next.green      = pix_c[15:8];
                        result_next.red        = pix_c[23:16];
                        result_next.alpha      =
                            (bits_per_pixel_reg == tga_rle_pkg::DEPTH_32 && alpha8_c)
                            ? abyte_c : tga_rle_pkg::ALPHA_OPAQUE;
                        result_next.column     = 16'(column_count_reg);
                        result_next.row        = 16'(row_c);
                        result_next.run_length = len_c;

                        col_sum_c = {1'b0, 16'(column_count_reg)} + {9'd0, len_c};
                        if (col_sum_c >= {1'b0, image_columns_reg})
                        begin
                            column_count_next = '0;
                            row_count_next    = row_inc_c[COORD_BITS-1:0];
                            if (17'(row_inc_c) >= {1'b0, image_rows_reg})
                            begin
                                final_c  = 1'b1;
                                status_c = tga_rle_pkg::ST_OK;
                            end
                        end
                        else
                        begin
                            column_count_next = col_sum_c[COORD_BITS-1:0];
                        end
                    end
                end

                default:
                begin
                    clear_c = in_ch.end_of_file;
                end
            endcase

            if (phase_reg != tga_rle_pkg::PH_DONE)
            begin
                if (!final_c && in_ch.end_of_file)
                begin
                    final_c  = 1'b1;
                    status_c = tga_rle_pkg::ST_TRUNCATED;
                end
                give_c = final_c || emit_c;
                if (final_c)
                begin
                    if (in_ch.end_of_file)
                        clear_c = 1'b1;
                    else
                        phase_next = tga_rle_pkg::PH_DONE;
                end
            end
        end

        result_next.final_res = final_c;
        result_next.status    = status_c;
        result_next.has_alpha = alpha8_c;

        if (clear_c)
        begin
            phase_next            = tga_rle_pkg::PH_HEADER;
            header_index_next     = 5'd0;
            id_skip_left_next     = 8'd0;
            colormap_present_next = 1'b0;
            image_kind_next       = 8'd0;
            bits_per_pixel_next   = 8'd0;
            attribute_bits_next   = 8'd0;
            image_columns_next    = 16'd0;
            image_rows_next       = 16'd0;
            column_count_next     = '0;
            row_count_next        = '0;
            packet_left_next      = 8'd0;
            packet_repeats_next   = 1'b0;
            pixel_byte_index_next = 2'd0;
            pixel_bytes_next      = 24'd0;
        end

        // hold a waiting beat, load a new one, drop a taken one
        if (give_c)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= tga_rle_pkg::PH_HEADER;
            header_index_reg     <= 5'd0;
            id_skip_left_reg     <= 8'd0;
            colormap_present_reg <= 1'b0;
            image_kind_reg       <= 8'd0;
            bits_per_pixel_reg   <= 8'd0;
            attribute_bits_reg   <= 8'd0;
            image_columns_reg    <= 16'd0;
            image_rows_reg       <= 16'd0;
            column_count_reg     <= '0;
            row_count_reg        <= '0;
            packet_left_reg      <= 8'd0;
            packet_repeats_reg   <= 1'b0;
            pixel_byte_index_reg <= 2'd0;
            pixel_bytes_reg      <= 24'd0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            phase_reg            <= phase_next;
            header_index_reg     <= header_index_next;
            id_skip_left_reg     <= id_skip_left_next;
            colormap_present_reg <= colormap_present_next;
            image_kind_reg       <= image_kind_next;
            bits_per_pixel_reg   <= bits_per_pixel_next;
            attribute_bits_reg   <= attribute_bits_next;
            image_columns_reg    <= image_columns_next;
            image_rows_reg       <= image_rows_next;
            column_count_reg     <= column_count_next;
            row_count_reg        <= row_count_next;
            packet_left_reg      <= packet_left_next;
            packet_repeats_reg   <= packet_repeats_next;
            pixel_byte_index_reg <= pixel_byte_index_next;
            pixel_bytes_reg      <= pixel_bytes_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (give_c)
            result_reg <= result_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.red        = result_reg.red;
    assign out_ch.green      = result_reg.green;
    assign out_ch.blue       = result_reg.blue;
    assign out_ch.alpha      = result_reg.alpha;
    assign out_ch.column     = result_reg.column;
    assign out_ch.row        = result_reg.row;
    assign out_ch.run_length = result_reg.run_length;
    assign out_ch.final_res  = result_reg.final_res;
    assign out_ch.status     = result_reg.status;
    assign out_ch.has_alpha  = result_reg.has_alpha;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ============================================================================
// TGA RLE stream decoder testbench
// Streams short TGA files, well formed and broken, through the decoder under
// several limit settings and flow-control patterns, predicts every pixel run
// and status beat in step with the input, and checks each output beat.
// ============================================================================
`default_nettype none

module tb_top;

    localparam int unsigned CYCLE_LIMIT     = 600000;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned BEATS_PER_PHASE = 275;
    localparam int unsigned FILE_CAP        = 700;

    typedef struct {
        logic [7:0] data;
        logic       eof;
    } beat_t;

    typedef struct {
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic [7:0]           alpha;
        logic [15:0]          column;
        logic [15:0]          row;
        logic [7:0]           run_length;
        logic                 final_res;
        tga_rle_pkg::status_t status;
        logic                 has_alpha;
    } run_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [15:0] cfg_data;

    tga_rle_in_if  in_ch ();
    tga_rle_out_if out_ch ();

    tga_rle_stream_decoder #(.COORD_BITS(16)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #1 clk = ~clk;

    beat_t       pending_beats[$];
    run_t        expected_runs[$];
    beat_t       cur_beat;
    run_t        exp_run;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;
    int unsigned phase_beats    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // decoder image of the block
    logic [15:0]         lim_w;
    logic [15:0]         lim_h;
    tga_rle_pkg::phase_t ph;
    logic [4:0]          hdr_pos;
    logic [7:0]          id_left;
    logic                cmap_flag;
    logic [7:0]          img_kind;
    logic [7:0]          depth;
    logic [7:0]          attr;
    logic [15:0]         img_w;
    logic [15:0]         img_h;
    logic [15:0]         col_pos;
    logic [15:0]         row_pos;
    logic [7:0]          pkt_left;
    logic                pkt_rep;
    logic [1:0]          pix_idx;
    logic [23:0]         pix_acc;

    function automatic int unsigned min_u(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] rnd_byte();
        int unsigned k;
        k = $urandom_range(0, 7);
        if (k == 0)
        begin
            return 8'h00;
        end
        if (k == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    task automatic restart_file();
        ph        = tga_rle_pkg::PH_HEADER;
        hdr_pos   = '0;
        id_left   = '0;
        cmap_flag = 1'b0;
        img_kind  = '0;
        depth     = '0;
        attr      = '0;
        img_w     = '0;
        img_h     = '0;
        col_pos   = '0;
        row_pos   = '0;
        pkt_left  = '0;
        pkt_rep   = 1'b0;
        pix_idx   = '0;
        pix_acc   = '0;
    endtask

    function automatic tga_rle_pkg::status_t header_verdict();
        if (img_w == 0 || img_w > lim_w || img_h == 0 || img_h > lim_h)
        begin
            return tga_rle_pkg::ST_SIZE;
        end
        if (cmap_flag)
        begin
            return tga_rle_pkg::ST_COLORMAP;
        end
        if ((img_kind != tga_rle_pkg::KIND_RAW && img_kind != tga_rle_pkg::KIND_RLE) ||
            (depth != tga_rle_pkg::DEPTH_24 && depth != tga_rle_pkg::DEPTH_32))
        begin
            return tga_rle_pkg::ST_TYPE_DEPTH;
        end
        if ((attr & tga_rle_pkg::ATTR_RIGHT) != 0
            || (attr[3:0] != 4'd0 && attr[3:0] != tga_rle_pkg::ALPHA_BITS_8))
        begin
            return tga_rle_pkg::ST_ATTRIB;
        end
        return tga_rle_pkg::ST_OK;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic eof);
        run_t                 r;
        logic                 fin;
        logic                 emit;
        logic                 a8;
        tga_rle_pkg::status_t st;
        logic [7:0]           abyte;
        logic [7:0]           run;
        logic [7:0]           len;
        int unsigned          nbytes;
        int unsigned          nxt;
        fin          = 1'b0;
        emit         = 1'b0;
        st           = tga_rle_pkg::ST_OK;
        len          = 8'd0;
        a8           = (attr & tga_rle_pkg::ATTR_ALPHA_MSK)
                       == 8'(tga_rle_pkg::ALPHA_BITS_8);
        r.red        = 8'd0;
        r.green      = 8'd0;
        r.blue       = 8'd0;
        r.alpha      = 8'd0;
        r.column     = 16'd0;
        r.row        = 16'd0;
        r.run_length = 8'd0;
        r.final_res  = 1'b0;
        r.status     = tga_rle_pkg::ST_OK;
        r.has_alpha  = 1'b0;
        if (ph == tga_rle_pkg::PH_DONE)
        begin
            if (eof)
            begin
                restart_file();
            end
        end
        else
        begin
            case (ph)
                tga_rle_pkg::PH_HEADER:
                begin
                    case (hdr_pos)
                        tga_rle_pkg::HDR_ID_LEN:    id_left = b;
                        tga_rle_pkg::HDR_CMAP:      cmap_flag = (b != 8'd0);
                        tga_rle_pkg::HDR_KIND:      img_kind = b;
                        tga_rle_pkg::HDR_WIDTH_LO:  img_w[7:0] = b;
                        tga_rle_pkg::HDR_WIDTH_HI:  img_w[15:8] = b;
                        tga_rle_pkg::HDR_HEIGHT_LO: img_h[7:0] = b;
                        tga_rle_pkg::HDR_HEIGHT_HI: img_h[15:8] = b;
                        tga_rle_pkg::HDR_DEPTH:     depth = b;
                        tga_rle_pkg::HDR_ATTR:      attr = b;
                        default: ;
                    endcase
                    if (hdr_pos < tga_rle_pkg::HDR_ATTR)
                    begin
                        hdr_pos++;
                    end
                    else
                    begin
                        a8 = (attr & tga_rle_pkg::ATTR_ALPHA_MSK)
                             == 8'(tga_rle_pkg::ALPHA_BITS_8);
                        st = header_verdict();
                        if (st != tga_rle_pkg::ST_OK)
                        begin
                            fin = 1'b1;
                        end
                        else if (id_left != 8'd0)
                        begin
                            ph = tga_rle_pkg::PH_IDSKIP;
                        end
                        else
                        begin
                            ph = (img_kind == tga_rle_pkg::KIND_RLE)
                                 ? tga_rle_pkg::PH_PACKET : tga_rle_pkg::PH_PIXEL;
                        end
                    end
                end
                tga_rle_pkg::PH_IDSKIP:
                begin
                    id_left--;
                    if (id_left == 8'd0)
                    begin
                        ph = (img_kind == tga_rle_pkg::KIND_RLE)
                             ? tga_rle_pkg::PH_PACKET : tga_rle_pkg::PH_PIXEL;
                    end
                end
                tga_rle_pkg::PH_PACKET:
                begin
                    run     = 8'(b[6:0]) + 8'd1;
                    pkt_rep = b[7];
                    if (32'(col_pos) + 32'(run) > 32'(img_w))
                    begin
                        st  = tga_rle_pkg::ST_OVERFLOW;
                        fin = 1'b1;
                    end
                    else
                    begin
                        pkt_left = run;
                        pix_idx  = 2'd0;
                        ph       = tga_rle_pkg::PH_PIXEL;
                    end
                end
                default:
                begin
                    nbytes = (depth == tga_rle_pkg::DEPTH_32) ? 4 : 3;
                    abyte  = tga_rle_pkg::ALPHA_OPAQUE;
                    if (pix_idx == 2'd0)
                    begin
                        pix_acc = {16'd0, b};
                    end
                    else if (pix_idx < 2'd3)
                    begin
                        pix_acc = pix_acc | (24'(b) << (8 * pix_idx));
                    end
                    else
                    begin
                        abyte = b;
                    end
                    nxt = pix_idx + 1;
                    if (nxt >= nbytes)
                    begin
                        pix_idx  = 2'd0;
                        emit     = 1'b1;
                        r.blue   = pix_acc[7:0];
                        r.green  = pix_acc[15:8];
                        r.red    = pix_acc[23:16];
                        r.alpha  = (depth == tga_rle_pkg::DEPTH_32 && a8)
                                   ? abyte : tga_rle_pkg::ALPHA_OPAQUE;
                        r.column = col_pos;
                        r.row    = ((attr & tga_rle_pkg::ATTR_TOP_DOWN) != 0)
                                   ? row_pos : img_h - 16'd1 - row_pos;
                        if (img_kind == tga_rle_pkg::KIND_RLE)
                        begin
                            if (pkt_rep)
                            begin
                                len      = pkt_left;
                                pkt_left = 8'd0;
                            end
                            else
                            begin
                                len = 8'd1;
                                pkt_left--;
                            end
                            if (pkt_left == 8'd0)
                            begin
                                ph = tga_rle_pkg::PH_PACKET;
                            end
                        end
                        else
                        begin
                            len = 8'd1;
                        end
                        col_pos = col_pos + 16'(len);
                        if (col_pos >= img_w)
                        begin
                            col_pos = 16'd0;
                            row_pos++;
                            if (row_pos >= img_h)
                            begin
                                fin = 1'b1;
                                st  = tga_rle_pkg::ST_OK;
                            end
                        end
                    end
                    else
                    begin
                        pix_idx = nxt[1:0];
                    end
                end
            endcase
            if (!fin && eof)
            begin
                fin = 1'b1;
                st  = tga_rle_pkg::ST_TRUNCATED;
            end
            if (fin || emit)
            begin
                r.run_length = len;
                r.final_res  = fin;
                r.status     = st;
                r.has_alpha  = a8;
                expected_runs.push_back(r);
                if (fin)
                begin
                    if (eof)
                    begin
                        restart_file();
                    end
                    else
                    begin
                        ph = tga_rle_pkg::PH_DONE;
                    end
                end
            end
        end
    endtask

    task automatic push_bytes(input logic [7:0] fb[$]);
        beat_t bt;
        for (int i = 0; i < fb.size(); i++)
        begin
            bt.data = fb[i];
            bt.eof  = (i == fb.size() - 1);
            pending_beats.push_back(bt);
            phase_beats++;
        end
    endtask

    task automatic queue_file();
        logic [7:0]  fb[$];
        logic [7:0]  kind;
        logic [7:0]  bpp;
        logic [7:0]  at;
        logic [7:0]  cmap;
        int unsigned sel;
        int unsigned w;
        int unsigned h;
        int unsigned idlen;
        int unsigned nb;
        int unsigned col;
        int unsigned row;
        int unsigned run;
        int unsigned k;
        bit          bad_hdr;
        bit          ovf;
        bit          trunc;
        bit          wide;
        bit          stop;
        bit          rep;
        sel     = $urandom_range(0, 99);
        trunc   = (sel >= 70 && sel < 78);
        bad_hdr = (sel >= 78 && sel < 88);
        ovf     = (sel >= 88 && sel < 94);
        kind    = (ovf || $urandom_range(0, 1)) ? tga_rle_pkg::KIND_RLE
                                                : tga_rle_pkg::KIND_RAW;
        bpp     = $urandom_range(0, 1) ? tga_rle_pkg::DEPTH_32 : tga_rle_pkg::DEPTH_24;
        at      = 8'($urandom_range(0, 3) << 6);
        if ($urandom_range(0, 1))
        begin
            at = at | tga_rle_pkg::ATTR_TOP_DOWN;
        end
        if ($urandom_range(0, 2) != 0)
        begin
            at = at | 8'(tga_rle_pkg::ALPHA_BITS_8);
        end
        cmap = 8'h00;
        wide = (kind == tga_rle_pkg::KIND_RLE && !ovf && lim_w >= 130
                && $urandom_range(0, 7) == 0);
        if (wide)
        begin
            w = $urandom_range(129, min_u(lim_w, 260));
            h = 1;
        end
        else
        begin
            w = $urandom_range(1, min_u(lim_w, 6));
            h = $urandom_range(1, min_u(lim_h, 4));
        end
        if (trunc && $urandom_range(0, 2) == 0)
        begin
            w = $urandom_range(1, lim_w);
            h = $urandom_range(1, lim_h);
        end
        k     = $urandom_range(0, 49);
        idlen = (k == 0) ? 255 : (k < 35) ? 0 : $urandom_range(1, 6);
        if (bad_hdr)
        begin
            repeat ($urandom_range(1, 2))
            begin
                case ($urandom_range(0, 4))
                    0: cmap = 8'($urandom_range(1, 255));
                    1:
                    begin
                        kind = rnd_byte();
                        if (kind == tga_rle_pkg::KIND_RAW || kind == tga_rle_pkg::KIND_RLE)
                        begin
                            kind++;
                        end
                    end
                    2:
                    begin
                        bpp = rnd_byte();
                        if (bpp == tga_rle_pkg::DEPTH_24 || bpp == tga_rle_pkg::DEPTH_32)
                        begin
                            bpp++;
                        end
                    end
                    3:
                    begin
                        if ($urandom_range(0, 1))
                        begin
                            at = at | tga_rle_pkg::ATTR_RIGHT;
                        end
                        else
                        begin
                            k = $urandom_range(1, 15);
                            if (k == 8)
                            begin
                                k = 9;
                            end
                            at = (at & ~tga_rle_pkg::ATTR_ALPHA_MSK) | 8'(k);
                        end
                    end
                    default:
                    begin
                        if ($urandom_range(0, 1))
                        begin
                            w = (lim_w < 16'hFFFF && $urandom_range(0, 1)) ? lim_w + 1 : 0;
                        end
                        else
                        begin
                            h = (lim_h < 16'hFFFF && $urandom_range(0, 1)) ? lim_h + 1 : 0;
                        end
                    end
                endcase
            end
        end
        fb.push_back(8'(idlen));
        fb.push_back(cmap);
        fb.push_back(kind);
        repeat (9) fb.push_back(rnd_byte());
        fb.push_back(w[7:0]);
        fb.push_back(w[15:8]);
        fb.push_back(h[7:0]);
        fb.push_back(h[15:8]);
        fb.push_back(bpp);
        fb.push_back(at);
        repeat (idlen) fb.push_back(rnd_byte());
        if (bad_hdr)
        begin
            repeat ($urandom_range(0, 3)) fb.push_back(rnd_byte());
        end
        else
        begin
            nb   = (bpp == tga_rle_pkg::DEPTH_32) ? 4 : 3;
            row  = 0;
            stop = 1'b0;
            while (!stop && row < h && fb.size() < FILE_CAP)
            begin
                col = 0;
                while (!stop && col < w && fb.size() < FILE_CAP)
                begin
                    if (kind != tga_rle_pkg::KIND_RLE)
                    begin
                        repeat (nb) fb.push_back(rnd_byte());
                        col++;
                    end
                    else if (ovf)
                    begin
                        if (col == 0 && w > 1 && $urandom_range(0, 1))
                        begin
                            run = $urandom_range(1, w - 1);
                            fb.push_back(8'h80 | 8'(run - 1));
                            repeat (nb) fb.push_back(rnd_byte());
                            col = run;
                        end
                        run = $urandom_range(w - col + 1, 128);
                        fb.push_back({1'($urandom_range(0, 1)), 7'(run - 1)});
                        stop = 1'b1;
                    end
                    else
                    begin
                        run = ($urandom_range(0, 3) == 0) ? min_u(128, w - col)
                                                          : $urandom_range(1, min_u(128, w - col));
                        rep = wide ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
                        if (!rep && run > 8)
                        begin
                            run = $urandom_range(1, 8);
                        end
                        fb.push_back({rep, 7'(run - 1)});
                        repeat (rep ? 1 : run)
                        begin
                            repeat (nb) fb.push_back(rnd_byte());
                        end
                        col += run;
                    end
                end
                row++;
            end
        end
        if (trunc)
        begin
            k = $urandom_range(1, fb.size() - 1);
            while (fb.size() > k)
            begin
                void'(fb.pop_back());
            end
        end
        else if (sel >= 94)
        begin
            repeat ($urandom_range(1, 4)) fb.push_back(rnd_byte());
        end
        push_bytes(fb);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == tga_rle_pkg::CFG_MAX_WIDTH)
        begin
            lim_w = val;
        end
        else
        begin
            lim_h = val;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_beats.size() != 0 || in_ch.valid || expected_runs.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // input driver: predict each accepted beat, then offer the next one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.data_byte   <= 8'd0;
            in_ch.end_of_file <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                decode_byte(in_ch.data_byte, in_ch.end_of_file);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_beat = pending_beats.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.data_byte   <= cur_beat.data;
                    in_ch.end_of_file <= cur_beat.eof;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_runs.size() == 0)
            begin
                $error("run beat with nothing expected");
                fail_count++;
            end
            else
            begin
                exp_run = expected_runs.pop_front();
                check_field("red", exp_run.red, out_ch.red);
                check_field("green", exp_run.green, out_ch.green);
                check_field("blue", exp_run.blue, out_ch.blue);
                check_field("alpha", exp_run.alpha, out_ch.alpha);
                check_field("column", exp_run.column, out_ch.column);
                check_field("row", exp_run.row, out_ch.row);
                check_field("run_length", exp_run.run_length, out_ch.run_length);
                check_field("final_res", exp_run.final_res, out_ch.final_res);
                check_field("status", exp_run.status, out_ch.status);
                check_field("has_alpha", exp_run.has_alpha, out_ch.has_alpha);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] dir_q[$];
        rst_n     = 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= tga_rle_pkg::CFG_MAX_WIDTH;
        cfg_data  <= 16'd0;
        lim_w = tga_rle_pkg::MAX_WIDTH_RESET;
        lim_h = tga_rle_pkg::MAX_HEIGHT_RESET;
        restart_file();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                1:
                begin
                    write_reg(tga_rle_pkg::CFG_MAX_WIDTH, 16'hFFFF);
                    write_reg(tga_rle_pkg::CFG_MAX_HEIGHT, 16'hFFFF);
                end
                2:
                begin
                    write_reg(tga_rle_pkg::CFG_MAX_WIDTH, 16'd1);
                    write_reg(tga_rle_pkg::CFG_MAX_HEIGHT, 16'd1);
                end
                3:
                begin
                    write_reg(tga_rle_pkg::CFG_MAX_WIDTH, 16'($urandom_range(130, 400)));
                    write_reg(tga_rle_pkg::CFG_MAX_HEIGHT, 16'($urandom_range(1, 6)));
                end
                4:
                begin
                    write_reg(tga_rle_pkg::CFG_MAX_WIDTH, 16'($urandom_range(1, 8)));
                    write_reg(tga_rle_pkg::CFG_MAX_HEIGHT, 16'hFFFF);
                end
                5:
                begin
                    write_reg(tga_rle_pkg::CFG_MAX_WIDTH, tga_rle_pkg::MAX_WIDTH_RESET);
                    write_reg(tga_rle_pkg::CFG_MAX_HEIGHT, 16'($urandom_range(2, 5)));
                end
                default: ;
            endcase
            @(posedge clk);
            cfg_write <= 1'b0;
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            @(negedge clk);
            phase_beats = 0;
            if (p == 0)
            begin
                // file cut off on its first header byte
                dir_q = {8'hFF};
                push_bytes(dir_q);
                // 1x1 top-down RLE image with 8 alpha bits, one repeat packet
                dir_q = {8'd0, 8'd0, tga_rle_pkg::KIND_RLE, 8'd0, 8'd0, 8'd0, 8'd0,
                         8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd1, 8'd0,
                         tga_rle_pkg::DEPTH_32,
                         tga_rle_pkg::ATTR_TOP_DOWN | 8'(tga_rle_pkg::ALPHA_BITS_8),
                         8'h80, 8'h00, 8'h7F, 8'hFF, 8'h80};
                push_bytes(dir_q);
            end
            while (phase_beats < BEATS_PER_PHASE)
            begin
                queue_file();
            end
            drain();
        end

        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
